>>> rtl/core/pidl_pkg.sv
package pidl_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int OPCODE_W     = 2;
	localparam int POS_W        = 7;
	localparam int WORD_W       = 32;
	localparam int STATUS_W     = 2;
	localparam int LENGTH_W     = 7;

	typedef enum logic [OPCODE_W-1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_POS   = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// shift command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctl_t;

endpackage

>>> rtl/core/pidl_cell.sv
module pidl_cell
	import pidl_pkg::*;
#(
	parameter int IW       = 6,
	parameter int CELL_IDX = 0
) (
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic [IW-1:0]            idx,
	input  logic signed [WORD_W-1:0] value,
	input  logic signed [WORD_W-1:0] left,
	input  logic signed [WORD_W-1:0] right,
	output logic signed [WORD_W-1:0] word,
	output logic signed [WORD_W-1:0] tap
);

	localparam logic [IW-1:0] MY = IW'(CELL_IDX);

	logic signed [WORD_W-1:0] word_q;
	logic signed [WORD_W-1:0] tap_q;

	// insert: load at idx, take left neighbour above it
	// delete: take right neighbour from idx upward
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (MY == idx) begin
				word_q <= value;
			end else if (MY > idx) begin
				word_q <= left;
			end
		end else if (ctl.del) begin
			if (MY >= idx) begin
				word_q <= right;
			end
		end
		// old word of the deleted cell, zero elsewhere
		tap_q <= (ctl.del && (MY == idx)) ? word_q : '0;
	end

	assign word = word_q;
	assign tap  = tap_q;

endmodule

>>> rtl/core/positional_insert_delete_list_top.sv
// Positional insert/delete list: the done strobe is registered through done_s1 and done_q after the accepting edge.
// Throughput one request per cycle; busy is held low, so a beat can be sent every cycle.
// Every cell shifts with its neighbour in the same cycle, so insert and delete take effect at the accepting edge;
// the removed word is then gathered from the registered cell taps into removed_q.
// Reset (arst_n low) clears the length and the result strobe; stored words are not cleared.
// Results cannot be stalled: each one is shown for exactly one cycle with done high.
module positional_insert_delete_list_top
	import pidl_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [OPCODE_W-1:0]        opcode,
	input  logic [POS_W-1:0]           position,
	input  logic signed [WORD_W-1:0]   value,
	output logic                       done,
	output logic [STATUS_W-1:0]        status,
	output logic signed [WORD_W-1:0]   removed_value,
	output logic [LENGTH_W-1:0]        list_length
);

	// count width holds CAPACITY itself; index width addresses the cells
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	// compare width: wide enough for position, count and count + 1
	localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_nx;
	logic [WW-1:0]   pos_w;
	logic [WW-1:0]   cnt_w;
	logic            full;
	status_t         st;
	logic            do_ins;
	logic            do_del;
	logic [IW-1:0]   idx;
	cell_ctl_t       ctl;

	logic                   done_s1;
	status_t                status_s1;
	logic [LENGTH_W-1:0]    length_s1;
	logic                   done_q;
	status_t                status_q;
	logic [LENGTH_W-1:0]    length_q;
	logic signed [WORD_W-1:0] removed_q;
	logic signed [WORD_W-1:0] tap_or;

	logic signed [WORD_W-1:0] words [CAPACITY];
	logic signed [WORD_W-1:0] taps  [CAPACITY];

	assign busy  = 1'b0;
	assign pos_w = WW'(position);
	assign cnt_w = WW'(count_q);
	assign full  = (cnt_w >= WW'(CAPACITY));

	// request decode: status, shift kind, target cell and next length
	always_comb begin
		st       = ST_OK;
		do_ins   = 1'b0;
		do_del   = 1'b0;
		idx      = '0;
		count_nx = count_q;
		unique case (op_t'(opcode))
			OP_APPEND: begin
				// append is an insert just past the last entry
				if (full) begin
					st = ST_FULL;
				end else begin
					do_ins   = 1'b1;
					idx      = IW'(count_q);
					count_nx = count_q + CW'(1);
				end
			end
			OP_INSERT: begin
				// position is checked before fullness
				priority if (pos_w == '0 || pos_w > cnt_w + WW'(1)) begin
					st = ST_POS;
				end else if (full) begin
					st = ST_FULL;
				end else begin
					do_ins   = 1'b1;
					idx      = IW'(pos_w - WW'(1));
					count_nx = count_q + CW'(1);
				end
			end
			OP_DELETE: begin
				// emptiness is checked before position
				priority if (cnt_w == '0) begin
					st = ST_EMPTY;
				end else if (pos_w == '0 || pos_w > cnt_w) begin
					st = ST_POS;
				end else begin
					do_del   = 1'b1;
					idx      = IW'(pos_w - WW'(1));
					count_nx = count_q - CW'(1);
				end
			end
			OP_CLEAR: begin
				// words stay in place; only the length drops
				count_nx = '0;
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	assign ctl.ins = start && do_ins;
	assign ctl.del = start && do_del;

	// row of cells, each wired to its neighbours; the first takes zero on the left, the last its own word on the right
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [WORD_W-1:0] left_w;
		logic signed [WORD_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = words[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = words[i];
		end else begin : g_mid_r
			assign right_w = words[i+1];
		end

		pidl_cell #(
			.IW       (IW),
			.CELL_IDX (i)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.idx   (idx),
			.value (value),
			.left  (left_w),
			.right (right_w),
			.word  (words[i]),
			.tap   (taps[i])
		);
	end

	// at most one tap is non-zero, so an OR gathers the removed word
	always_comb begin
		tap_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tap_or = tap_or | taps[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (start) begin
				count_q <= count_nx;
			end
			done_s1 <= start;
			done_q  <= done_s1;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		status_s1 <= st;
		length_s1 <= LENGTH_W'(count_nx);
		status_q  <= status_s1;
		length_q  <= length_s1;
		removed_q <= tap_or;
	end

	assign done          = done_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign list_length   = length_q;

endmodule

>>> rtl/core/pidl_checker.sv
module pidl_checker
	import pidl_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     done,
	input logic [STATUS_W-1:0]      status,
	input logic signed [WORD_W-1:0] removed_value,
	input logic [LENGTH_W-1:0]      list_length
);

	// every accepted beat is answered with done
	a_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted beat gave no result");

	// no result without an accepted beat before it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without request");

	// an empty-list refusal reports length zero
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (list_length == '0))
		else $error("empty status with non-zero length");

	// a non-zero removed word only on success
	a_removed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && removed_value != '0) |-> (status == ST_OK))
		else $error("removed word on failed request");

	// length never exceeds capacity
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(list_length) <= 32'(CAPACITY)))
		else $error("length beyond capacity");

endmodule

bind positional_insert_delete_list_top pidl_checker #(
	.CAPACITY (CAPACITY)
) u_pidl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.removed_value (removed_value),
	.list_length   (list_length)
);
